@@ rtl/bvjhd_pkg.sv @@
// ----------------------------------------------------------------------------
// bvjhd_pkg
// Shared types, constants and helpers for the bit-vector distance unit.
// ----------------------------------------------------------------------------
package bvjhd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned TotalW = 16;
  localparam int unsigned PcntW  = 6;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned CntW   = 5;

  // One quotient bit per divider step, bits 16 down to 0.
  localparam logic [CntW-1:0] DivLastStep = 5'd16;
  localparam logic [QuoW-1:0] QOne        = 17'h10000;

  typedef struct packed {
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic             last_word;
  } in_t;

  typedef struct packed {
    logic [TotalW-1:0] hamming_distance;
    logic [QuoW-1:0]   jaccard_distance;
    logic              saturated;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic acc;       // beat accepted, add its counts
    logic load;      // accepted beat is the last one: latch totals, start divide
    logic step;      // one restoring-divide step
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;  // this step produces the final quotient bit
  } sts_t;

  function automatic logic [PcntW-1:0] popcount32(input logic [WordW-1:0] v);
    logic [PcntW-1:0] n;
    n = '0;
    for (int i = 0; i < WordW; i++) begin
      n = n + PcntW'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ rtl/bvjhd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bvjhd_ctrl
// Sequencer: accumulate, divide, hand over result; owns both handshakes.
// ----------------------------------------------------------------------------
module bvjhd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bvjhd_pkg::cmd_t cmd_o,
  input  bvjhd_pkg::sts_t sts_i
);
  import bvjhd_pkg::*;

  localparam logic [1:0] StAcc = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       beat;

  assign in_stall_o  = (state_q != StAcc);
  assign out_valid_o = out_valid_q;
  assign beat        = in_valid_i && (state_q == StAcc);

  always_comb begin
    cmd_o          = '0;
    cmd_o.acc      = beat;
    cmd_o.load     = beat && in_last_i;
    cmd_o.step     = (state_q == StDiv);
    cmd_o.out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StAcc: begin
        if (cmd_o.load) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.div_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (cmd_o.out_load) begin
          state_d = StAcc;
        end
      end
      default: state_d = StAcc;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/bvjhd_dp.sv @@
// ----------------------------------------------------------------------------
// bvjhd_dp
// Saturating popcount totals, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module bvjhd_dp #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bvjhd_pkg::in_t   in_i,
  input  bvjhd_pkg::cmd_t  cmd_i,
  output bvjhd_pkg::sts_t  sts_o,
  output bvjhd_pkg::out_t  out_o
);
  import bvjhd_pkg::*;

  localparam int unsigned RawBound = MAX_WORDS * 32;
  localparam logic [TotalW-1:0] Bound =
    (RawBound > 65535) ? 16'hFFFF : TotalW'(RawBound);

  // running totals
  logic [TotalW-1:0] uni_q, int_q, dif_q;
  logic              sat_q;
  logic [TotalW-1:0] uni_n, int_n, dif_n;
  logic              sat_n;

  // divider and result holding
  logic [TotalW-1:0] div_q, rem_q, rem_d;
  logic [QuoW-1:0]   sh_q, quo_q;
  logic [CntW-1:0]   cnt_q;
  logic [TotalW-1:0] ham_q;
  logic              satr_q, zero_q;
  out_t              out_q;

  logic [TotalW:0]   su, si, sd;
  logic [TotalW:0]   trial;
  logic              ge;

  always_comb begin
    su = {1'b0, uni_q} + {11'b0, popcount32(in_i.word_a | in_i.word_b)};
    si = {1'b0, int_q} + {11'b0, popcount32(in_i.word_a & in_i.word_b)};
    sd = {1'b0, dif_q} + {11'b0, popcount32(in_i.word_a ^ in_i.word_b)};
    uni_n = (su > {1'b0, Bound}) ? Bound : su[TotalW-1:0];
    int_n = (si > {1'b0, Bound}) ? Bound : si[TotalW-1:0];
    dif_n = (sd > {1'b0, Bound}) ? Bound : sd[TotalW-1:0];
    sat_n = sat_q || (su > {1'b0, Bound}) || (si > {1'b0, Bound})
            || (sd > {1'b0, Bound});
  end

  // restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, sh_q[QuoW-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? TotalW'(trial - {1'b0, div_q}) : trial[TotalW-1:0];
  end

  assign sts_o.div_last = (cnt_q == DivLastStep);
  assign out_o          = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uni_q <= '0;
      int_q <= '0;
      dif_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.load) begin
      uni_q <= '0;
      int_q <= '0;
      dif_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.acc) begin
      uni_q <= uni_n;
      int_q <= int_n;
      dif_q <= dif_n;
      sat_q <= sat_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // dividend is inter << 16; its top 15 quotient bits are zero as inter <= union
      div_q  <= uni_n;
      rem_q  <= {1'b0, int_n[TotalW-1:1]};
      sh_q   <= {int_n[0], 16'b0};
      quo_q  <= '0;
      cnt_q  <= '0;
      ham_q  <= dif_n;
      satr_q <= sat_n;
      zero_q <= (uni_n == '0) || (int_n > uni_n);
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.out_load) begin
      out_q.hamming_distance <= ham_q;
      out_q.jaccard_distance <= zero_q ? '0 : (QOne - quo_q);
      out_q.saturated        <= satr_q;
    end
  end

endmodule

@@ rtl/bit_vector_jaccard_hamming_distance.sv @@
// ----------------------------------------------------------------------------
// bit_vector_jaccard_hamming_distance
// Streaming Hamming and Jaccard distance of two bit vectors.
// ----------------------------------------------------------------------------
// Word pairs are taken one beat per clock while the input is not stalled.
// Each beat adds the popcounts of a|b, a&b and a^b to three 16-bit totals,
// each clamped at min(MAX_WORDS*32, 65535); a clamp sets the saturated flag.
// The beat marked last_word closes the vector: the totals are latched and
// cleared, and a bit-serial restoring divider forms floor(inter*65536/union),
// one quotient bit per cycle. The result beat carries the Hamming distance
// and the Jaccard distance 65536 - quotient in unsigned Q1.16 (0 when the
// union is empty). The input stalls from the cycle after the last beat until
// the result enters the output register, and stays stalled while a previous
// result is still held there. Words inside a vector go at one per cycle.
// The output register lets a new vector stream in while a result waits.
// ----------------------------------------------------------------------------
module bit_vector_jaccard_hamming_distance #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bvjhd_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bvjhd_pkg::out_t out_o
);
  import bvjhd_pkg::*;

  localparam int unsigned RawBound = MAX_WORDS * 32;
  localparam logic [TotalW-1:0] Bound =
    (RawBound > 65535) ? 16'hFFFF : TotalW'(RawBound);

  cmd_t cmd;
  sts_t sts;

  bvjhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_i.last_word),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bvjhd_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  // A closing beat starts the divide, so the input must stall next cycle.
  a_last_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.last_word) |=> in_stall_o)
    else $error("input not stalled after last beat");

  // Divider steps only while the input is held off.
  a_step_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> in_stall_o)
    else $error("divider stepping while input open");

  // Q1.16 result never above 1.0.
  a_jd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.jaccard_distance <= QOne))
    else $error("jaccard distance above one");

  // Hamming total is clamped at the bound.
  a_ham_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.hamming_distance <= Bound))
    else $error("hamming distance above bound");

endmodule

@@ dv/bit_vector_jaccard_hamming_distance_tb.sv @@
// ----------------------------------------------------------------------------
// bit_vector_jaccard_hamming_distance_tb
// Self-checking bench for the streaming Hamming / Jaccard distance unit.
// ----------------------------------------------------------------------------
// Word pairs go in as vectors of random length and random bit density. A
// scoreboard keeps its own running totals and predicts one result per
// vector. Every result beat is compared field by field with the oldest
// prediction. The block is built with its default word bound. Vectors are
// kept short so that many results are checked. Both channels idle at random.
// One phase runs with no idling at all. The sink holds off long enough to
// back the block up into its input. The source drains the block fully twice.
// ----------------------------------------------------------------------------

class distance_scoreboard;

  int unsigned                       bound;
  logic [bvjhd_pkg::TotalW-1:0]      union_sum;
  logic [bvjhd_pkg::TotalW-1:0]      inter_sum;
  logic [bvjhd_pkg::TotalW-1:0]      diff_sum;
  logic                              clamped;
  bvjhd_pkg::out_t                   expected_q[$];
  int unsigned                       mismatches;

  function new(int unsigned max_words);
    bound      = (max_words * 32 > 65535) ? 65535 : max_words * 32;
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    union_sum = '0;
    inter_sum = '0;
    diff_sum  = '0;
    clamped   = 1'b0;
  endfunction

  // Clamp at the bound; landing exactly on it is not a clamp.
  function logic [bvjhd_pkg::TotalW-1:0] add_clamp(logic [bvjhd_pkg::TotalW-1:0] total,
                                                   int unsigned inc);
    int unsigned s;
    s = total + inc;
    if (s > bound) begin
      clamped = 1'b1;
      s = bound;
    end
    return bvjhd_pkg::TotalW'(s);
  endfunction

  function void note_input(bvjhd_pkg::in_t beat);
    longint unsigned                 quo;
    logic [bvjhd_pkg::QuoW-1:0]      jd;
    bvjhd_pkg::out_t                 r;
    union_sum = add_clamp(union_sum, $countones(beat.word_a | beat.word_b));
    inter_sum = add_clamp(inter_sum, $countones(beat.word_a & beat.word_b));
    diff_sum  = add_clamp(diff_sum, $countones(beat.word_a ^ beat.word_b));
    if (!beat.last_word) return;
    if (union_sum == 0 || inter_sum > union_sum) begin
      jd = '0;
    end else begin
      quo = (longint'(inter_sum) << 16) / union_sum;
      jd  = bvjhd_pkg::QOne - bvjhd_pkg::QuoW'(quo);
    end
    r.hamming_distance = diff_sum;
    r.jaccard_distance = jd;
    r.saturated        = clamped;
    expected_q.push_back(r);
    clear();
  endfunction

  function void check_result(bvjhd_pkg::out_t got);
    bvjhd_pkg::out_t exp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with no vector closed: ham %0d jd %0d sat %0b",
                 $realtime, got.hamming_distance, got.jaccard_distance, got.saturated);
      return;
    end
    exp = expected_q.pop_front();
    if (got.hamming_distance !== exp.hamming_distance ||
        got.jaccard_distance !== exp.jaccard_distance ||
        got.saturated !== exp.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: exp ham %0d jd %0d sat %0b, got ham %0d jd %0d sat %0b",
                 $realtime, exp.hamming_distance, exp.jaccard_distance, exp.saturated,
                 got.hamming_distance, got.jaccard_distance, got.saturated);
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

endclass

module bit_vector_jaccard_hamming_distance_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Default word bound of the block.
  localparam int unsigned MaxWords    = 1024;
  // Vector lengths: mostly short, some longer.
  localparam int unsigned ShortLen    = 8;
  localparam int unsigned LongLen     = 40;
  localparam int unsigned RandItems   = 550;
  localparam int unsigned IdlePct     = 18;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 40;
  // Longest honest silence is the sink hold-off plus a divide; keep well clear.
  localparam int unsigned StuckLimit  = 4000;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  bvjhd_pkg::in_t  in_beat;
  logic            out_valid;
  logic            out_stall;
  bvjhd_pkg::out_t out_beat;

  // Shared between stimulus and sink: quiet mode and the hold-off request.
  bit              quiet     = 1'b0;
  bit              hold_req  = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     items_sent = 0;

  distance_scoreboard sb = new(MaxWords);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bit_vector_jaccard_hamming_distance #(
    .MAX_WORDS(MaxWords)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_beat)
  );

  // Monitor: inputs are noted before results are checked; a result never
  // belongs to the beat accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_input(in_beat);
      if (out_valid && !out_stall) sb.check_result(out_beat);
    end
  end

  // Watchdog: ends the run after too many edges with no beat on either side.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("status: fail");
    $finish;
  end

  // Result sink, driven on the falling edge. A hold-off request freezes it
  // for a counted stretch so the output register and the divider back up.
  always begin : result_sink
    @(negedge clk_i);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IdlePct);
    end
  end

  // Offer one beat, starting on a falling edge; returns on the falling edge
  // after it is taken. Valid stays high across back-to-back beats.
  task automatic send_beat(logic [31:0] a, logic [31:0] b, logic last);
    int unsigned gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < IdlePct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid        <= 1'b1;
    in_beat.word_a    <= a;
    in_beat.word_b    <= b;
    in_beat.last_word <= last;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  // The same pair n times, the last one closing the vector.
  task automatic send_repeat(logic [31:0] a, logic [31:0] b, int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(a, b, i == n - 1);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & $urandom & $urandom;   // sparse
      3:       return $urandom | $urandom;              // dense
      4:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vector(int unsigned len);
    logic [31:0] a;
    logic [31:0] b;
    int unsigned roll;
    for (int unsigned i = 0; i < len; i++) begin
      a    = pick_word();
      roll = $urandom_range(99);
      if (roll < 15)      b = a;
      else if (roll < 25) b = ~a;
      else                b = pick_word();
      send_beat(a, b, i == len - 1);
    end
  endtask

  // Mostly short vectors, a quarter of them longer.
  task automatic run_vectors(int unsigned n);
    int unsigned stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 75) send_vector($urandom_range(ShortLen, 1));
      else                         send_vector($urandom_range(LongLen, ShortLen + 1));
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_beat   = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty union, identical, disjoint, partial overlap.
    send_repeat(32'h0000_0000, 32'h0000_0000, 1);
    send_repeat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_repeat(32'hFFFF_FFFF, 32'h0000_0000, 1);
    send_repeat(32'h0000_0001, 32'h0000_0003, 1);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_beat(32'hF0F0_F0F0, 32'hFF00_FF00, 1'b1);

    // Random with idling on both sides.
    run_vectors(RandItems * 4 / 10);

    // Back to back, no idling anywhere.
    quiet = 1'b1;
    run_vectors(RandItems * 2 / 10);
    quiet = 1'b0;

    // Sink holds off while short vectors keep coming: input must stall.
    hold_req = 1'b1;
    repeat (8) send_vector(2);

    // Let the block drain completely before carrying on.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);

    run_vectors(RandItems * 4 / 10);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ bit_vector_jaccard_hamming_distance.f @@
rtl/bvjhd_pkg.sv
rtl/bvjhd_ctrl.sv
rtl/bvjhd_dp.sv
rtl/bit_vector_jaccard_hamming_distance.sv
dv/bit_vector_jaccard_hamming_distance_tb.sv
